// ===== rtl/pbl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_pkg
// Shared types, codes and helper functions for the panel button/LED
// controller.
// ----------------------------------------------------------------------------
package pbl_pkg;

	// Transaction kinds
	localparam logic MODE_SCAN = 1'b0;
	localparam logic MODE_NOTE = 1'b1;

	// Transpose capture phases
	localparam logic [1:0] CAP_IDLE = 2'd0;
	localparam logic [1:0] CAP_FROM = 2'd1;
	localparam logic [1:0] CAP_TO   = 2'd2;

	// Button masks
	localparam logic [7:0] BTN_BOTH = 8'hC0;
	localparam logic [7:0] BTN_UP   = 8'h80;
	localparam logic [7:0] BTN_DOWN = 8'h40;
	localparam logic [7:0] BTN_CH_A = 8'h02;
	localparam logic [7:0] BTN_CH_B = 8'h04;
	localparam logic [7:0] BTN_CH_C = 8'h08;
	localparam logic [7:0] BTN_CH_D = 8'h10;
	localparam logic [7:0] BTN_CH_E = 8'h20;

	// LED masks
	localparam logic [7:0] LED_UP      = 8'h80;
	localparam logic [7:0] LED_DOWN    = 8'h40;
	localparam logic [7:0] LED_CH_MASK = 8'h3F;

	localparam logic [4:0] CH_RESET   = 5'd1;
	localparam logic [4:0] CH_UNKNOWN = 5'd16;
	localparam logic signed [9:0] TRANS_STEP = 10'sd2;

	// Input transaction payload
	typedef struct packed {
		logic       mode;
		logic [7:0] raw_buttons;
		logic [6:0] note;
	} item_t;

	// Panel state seen by the LED logic
	typedef struct packed {
		logic [7:0] held;
		logic       released;
		logic [4:0] channel;
		logic [7:0] transpose;  // two's complement
		logic [1:0] capture;
		logic       blink;
	} panel_state_t;

	// State after the current transaction
	typedef struct packed {
		logic [4:0] channel;
		logic [7:0] transpose;
		logic [1:0] capture;
		logic       fired;
	} update_t;

	// Channel to LED index
	function automatic logic [2:0] chan_led(input logic [4:0] c);
		logic [2:0] r;
		case (c)
			5'd1, 5'd5, 5'd9:    r = 3'd1;
			5'd2, 5'd6, 5'd10:   r = 3'd2;
			5'd3, 5'd7, 5'd11:   r = 3'd3;
			5'd4, 5'd8, 5'd12:   r = 3'd4;
			5'd13, 5'd14, 5'd15: r = 3'd5;
			default:             r = 3'd0;
		endcase
		return r;
	endfunction

	// Step through a three-channel group
	function automatic logic [4:0] next_channel(input logic [4:0] c, input logic [4:0] a,
			input logic [4:0] b, input logic [4:0] d);
		logic [4:0] r;
		if (c == a) begin
			r = b;
		end else if (c == b) begin
			r = d;
		end else begin
			r = a;
		end
		return r;
	endfunction

	// Saturate to the signed 8-bit range
	function automatic logic [7:0] sat8(input logic signed [9:0] v);
		logic [7:0] r;
		if (v > 10'sd127) begin
			r = 8'h7F;
		end else if (v < -10'sd128) begin
			r = 8'h80;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pbl_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_in_if
// Input channel: scan or note transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pbl_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] raw_buttons;
	logic [6:0] note;

	modport source (output valid, output mode, output raw_buttons, output note,
		input ready);
	modport sink (input valid, input mode, input raw_buttons, input note,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/pbl_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_out_if
// Output channel: one result transaction per input transaction.
// ----------------------------------------------------------------------------
interface pbl_out_if;
	logic              valid;
	logic              ready;
	logic [7:0]        led_bits;
	logic [4:0]        channel_out;
	logic signed [7:0] transpose_out;
	logic [1:0]        capture_out;
	logic              fired;

	modport source (output valid, output led_bits, output channel_out,
		output transpose_out, output capture_out, output fired, input ready);
	modport sink (input valid, input led_bits, input channel_out,
		input transpose_out, input capture_out, input fired, output ready);
endinterface
`default_nettype wire

// ===== rtl/pbl_led_map.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_led_map
// LED pattern from the panel state as it stood before the scan.
// ----------------------------------------------------------------------------
module pbl_led_map (
	input  wire pbl_pkg::panel_state_t st,
	output logic [7:0]                 leds
);
	import pbl_pkg::*;

	logic [7:0] base;

	assign base = 8'd1 << chan_led(st.channel);

	always_comb begin
		if (st.held != 8'd0 && !st.released) begin
			// combo held: mirror buttons
			leds = st.held;
		end else if (st.capture != CAP_IDLE) begin
			// capturing: alternate blink on the two top LEDs
			leds = (base & LED_CH_MASK) | (st.blink ? LED_UP : LED_DOWN);
		end else if (!st.transpose[7] && st.transpose != 8'd0) begin
			leds = base | LED_UP;
		end else if (st.transpose[7]) begin
			leds = base | LED_DOWN;
		end else begin
			leds = base;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pbl_panel_fsm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbl_panel_fsm
// Panel state registers and their update for one transaction.
// ----------------------------------------------------------------------------
module pbl_panel_fsm (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire pbl_pkg::item_t   item,
	output pbl_pkg::panel_state_t st,
	output pbl_pkg::update_t      upd
);
	import pbl_pkg::*;

	logic [7:0] held_q, held_n;
	logic       rel_q, rel_n;
	logic [4:0] chan_q, chan_n;
	logic [7:0] trans_q, trans_n;
	logic [1:0] cap_q, cap_n;
	logic [6:0] from_q, from_n;
	logic [2:0] cnt_q, cnt_n;
	logic       fired_n;
	logic [7:0] btn;
	logic signed [9:0] trans_w;
	logic signed [9:0] from_w;
	logic signed [9:0] note_w;

	assign btn     = ~item.raw_buttons;
	assign trans_w = {{2{trans_q[7]}}, trans_q};
	assign from_w  = {3'b000, from_q};
	assign note_w  = {3'b000, item.note};

	// Next state
	always_comb begin
		held_n  = held_q;
		rel_n   = rel_q;
		chan_n  = chan_q;
		trans_n = trans_q;
		cap_n   = cap_q;
		from_n  = from_q;
		cnt_n   = cnt_q;
		fired_n = 1'b0;
		if (item.mode == MODE_SCAN) begin
			cnt_n  = cnt_q + 3'd1;
			held_n = btn;
			if (held_q > btn && !rel_q) begin
				// combo released: act on it once
				rel_n   = 1'b1;
				fired_n = 1'b1;
				if ((held_q & BTN_BOTH) == BTN_BOTH) begin
					if (cap_q != CAP_IDLE) begin
						cap_n   = CAP_IDLE;
						trans_n = 8'd0;
					end else begin
						cap_n = CAP_FROM;
					end
				end else if ((held_q & BTN_UP) != 8'd0) begin
					trans_n = sat8(trans_w + TRANS_STEP);
				end else if ((held_q & BTN_DOWN) != 8'd0) begin
					trans_n = sat8(trans_w - TRANS_STEP);
				end else begin
					case (held_q)
						BTN_CH_A: chan_n = next_channel(chan_q, 5'd1, 5'd5, 5'd9);
						BTN_CH_B: chan_n = next_channel(chan_q, 5'd2, 5'd6, 5'd10);
						BTN_CH_C: chan_n = next_channel(chan_q, 5'd3, 5'd7, 5'd11);
						BTN_CH_D: chan_n = next_channel(chan_q, 5'd4, 5'd8, 5'd12);
						BTN_CH_E: chan_n = next_channel(chan_q, 5'd13, 5'd14, 5'd15);
						default:  chan_n = CH_UNKNOWN;
					endcase
				end
			end else if (held_q < btn) begin
				rel_n = 1'b0;
			end
		end else begin
			// note transaction advances a pending capture or completes it
			if (cap_q == CAP_FROM) begin
				from_n = item.note;
				cap_n  = CAP_TO;
			end else if (cap_q == CAP_TO) begin
				trans_n = sat8(trans_w + from_w - note_w);
				cap_n   = CAP_IDLE;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 8'd0;
			rel_q   <= 1'b1;
			chan_q  <= CH_RESET;
			trans_q <= 8'd0;
			cap_q   <= CAP_IDLE;
			cnt_q   <= 3'd0;
		end else if (adv) begin
			held_q  <= held_n;
			rel_q   <= rel_n;
			chan_q  <= chan_n;
			trans_q <= trans_n;
			cap_q   <= cap_n;
			cnt_q   <= cnt_n;
		end
	end

	// Captured from-note, no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			from_q <= from_n;
		end
	end

	assign st.held      = held_q;
	assign st.released  = rel_q;
	assign st.channel   = chan_q;
	assign st.transpose = trans_q;
	assign st.capture   = cap_q;
	assign st.blink     = cnt_q[2];

	assign upd.channel   = chan_n;
	assign upd.transpose = trans_n;
	assign upd.capture   = cap_n;
	assign upd.fired     = fired_n;

endmodule
`default_nettype wire

// ===== rtl/panel_button_led_controller_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// panel_button_led_controller_unit
// Front-panel controller for eight buttons and eight LEDs.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the result register is free
// or its result is taken, and returns exactly one result transaction for each,
// in order. A transaction passes an input register and then the state update,
// which is written together with the result register, so the result becomes
// valid once the transaction moves from the input register to the result
// register; a stall on the output holds it in the input register. The
// result register lets a new transaction enter while a result still waits on
// the output. LED bits and the fired flag are zero on note transactions.
// ----------------------------------------------------------------------------
module panel_button_led_controller_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	pbl_in_if.sink    panel,
	pbl_out_if.source report
);
	import pbl_pkg::*;

	logic         v_s1;
	item_t        item_s1;
	logic         v_s2;
	logic         adv;
	logic         take;
	panel_state_t st;
	update_t      upd;
	logic [7:0]   leds;

	// Handshake: stage 1 moves when the result register is free or draining
	assign adv         = v_s1 && (!v_s2 || report.ready);
	assign panel.ready = !v_s1 || adv;
	assign take        = panel.valid && panel.ready;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (report.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.mode        <= panel.mode;
			item_s1.raw_buttons <= panel.raw_buttons;
			item_s1.note        <= panel.note;
		end
	end

	pbl_panel_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.st     (st),
		.upd    (upd)
	);

	pbl_led_map u_led (
		.st   (st),
		.leds (leds)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			report.led_bits      <= (item_s1.mode == MODE_SCAN) ? leds : 8'd0;
			report.channel_out   <= upd.channel;
			report.transpose_out <= upd.transpose;
			report.capture_out   <= upd.capture;
			report.fired         <= upd.fired;
		end
	end

	assign report.valid = v_s2;

	// A fired combo always shows the held buttons on the LEDs
	a_fired_leds: assert property (@(posedge clk) disable iff (!arst_n)
		(report.valid && report.fired) |-> (report.led_bits != 8'd0))
		else $error("fired result with dark LEDs");

	// Transpose only moves when a transaction is processed
	a_trans_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(st.transpose))
		else $error("transpose changed without a transaction");

	// Capture reaches the to-note phase only from the from-note phase
	a_cap_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st.capture == CAP_TO && $past(st.capture) != CAP_TO)
		|-> ($past(st.capture) == CAP_FROM))
		else $error("capture skipped the from-note phase");

	// Voice channel stays within its range
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		st.channel <= CH_UNKNOWN)
		else $error("voice channel out of range");

endmodule
`default_nettype wire
